### design/ipr4_pkg.sv
// Shared constants and types for the 4-connected isolated pixel removal block.
package ipr4_pkg;

    localparam int PIX_W = 8;
    localparam int LW_W  = 12;

    localparam logic [PIX_W-1:0] FULL_VALUE = 8'd255;
    localparam logic [LW_W-1:0]  LINE_WIDTH_RESET = 12'd640;

    // Register map: byte addresses on the configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_LINE_WIDTH = 3'd0;

    // Meaning of the input kind field.
    typedef enum logic
    {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [LW_W-1:0]  line_width_t;

endpackage

### design/isolated_pixel_removal_4conn_unit.sv
// A pixel's result is computed when the pixel one row below it is accepted, then registered.
// Throughput: one transaction per cycle unless the output stalls; each row buffer access
// uses its RAM's single write port and single read port, with reads prefetched ahead.
// Reset clears the control state and sets line_width to 640; the row buffers are not
// cleared, and the first row of a frame is only stored, so no clearing pass is needed.
module isolated_pixel_removal_4conn_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Stream in: tdata = pixel_in[7:0]; tuser = kind[0]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,
    input  logic                             s_axis_tuser,
    // Stream out: tdata = pixel_out[7:0]; tlast = frame_end
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,
    output logic                             m_axis_tlast,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ipr4_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import ipr4_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = 1 << AW;
    localparam int EW    = (AW + 1 > LW_W) ? AW + 1 : LW_W;

    line_width_t line_width;

    // Control state
    logic [AW-1:0] column_reg, column_next;
    logic          have_pending_reg, have_pending_next;
    logic          have_above_reg, have_above_next;
    logic          left_full_reg, left_full_next;
    logic          out_valid_reg, out_valid_next;
    logic          pend_byp_valid_reg, pend_byp_valid_next;
    logic          flag_byp_valid_reg, flag_byp_valid_next;

    // Payload state
    pixel_t        cur_reg, cur_next;
    pixel_t        col0_reg, col0_next;
    pixel_t        out_pixel_reg, out_pixel_next;
    logic          out_last_reg, out_last_next;
    pixel_t        pend_byp_reg;
    logic          flag_byp_reg;

    // Datapath
    logic          accept;
    logic          flush;
    pixel_t        raw;
    logic [EW-1:0] w_eff;
    logic [EW-1:0] lw_ext;
    logic [EW-1:0] max_ext;
    logic          last_col;
    pixel_t        ahead;
    logic          above_flag;
    logic          any_full;
    pixel_t        res;
    logic          res_full;

    // RAM ports
    logic [AW-1:0] pend_raddr;
    pixel_t        pend_rdata;
    logic          flag_we;
    logic [AW-1:0] flag_raddr;
    logic          flag_rdata;

    ipr4_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .line_width (line_width)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign flush         = (kind_t'(s_axis_tuser) == KIND_FLUSH);
    assign raw           = flush ? '0 : s_axis_tdata;

    // Width 0 behaves as 1 and widths past the buffer size are clipped.
    assign lw_ext  = EW'(line_width);
    assign max_ext = EW'(MAX_WIDTH);
    always_comb
    begin
        if (line_width == '0)
        begin
            w_eff = EW'(1);
        end
        else if (lw_ext > max_ext)
        begin
            w_eff = max_ext;
        end
        else
        begin
            w_eff = lw_ext;
        end
    end

    assign last_col = (EW'(column_reg) + EW'(1)) >= w_eff;

    // A read that hit the address written in the same cycle takes the written value.
    assign ahead      = pend_byp_valid_reg ? pend_byp_reg : pend_rdata;
    assign above_flag = flag_byp_valid_reg ? flag_byp_reg : flag_rdata;

    always_comb
    begin
        any_full = 1'b0;
        if (have_above_reg && above_flag)
        begin
            any_full = 1'b1;
        end
        if ((column_reg != '0) && left_full_reg)
        begin
            any_full = 1'b1;
        end
        if (!flush && (raw == FULL_VALUE))
        begin
            any_full = 1'b1;
        end
        if (!last_col && (ahead == FULL_VALUE))
        begin
            any_full = 1'b1;
        end
        res      = ((cur_reg != '0) && !any_full) ? '0 : cur_reg;
        res_full = (res == FULL_VALUE);
    end

    always_comb
    begin
        column_next       = column_reg;
        have_pending_next = have_pending_reg;
        have_above_next   = have_above_reg;
        left_full_next    = left_full_reg;
        cur_next          = cur_reg;
        col0_next         = col0_reg;
        out_valid_next    = out_valid_reg;
        out_pixel_next    = out_pixel_reg;
        out_last_next     = out_last_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (have_pending_reg)
            begin
                left_full_next = res_full;
                out_valid_next = 1'b1;
                out_pixel_next = res;
                out_last_next  = flush && last_col;
            end
            if (column_reg == '0)
            begin
                col0_next = raw;
            end
            if (last_col)
            begin
                column_next    = '0;
                left_full_next = 1'b0;
                cur_next       = (column_reg == '0) ? raw : col0_reg;
                if (flush)
                begin
                    have_pending_next = 1'b0;
                    have_above_next   = 1'b0;
                end
                else
                begin
                    have_above_next   = have_pending_reg;
                    have_pending_next = 1'b1;
                end
            end
            else
            begin
                column_next = column_reg + AW'(1);
                cur_next    = ahead;
            end
        end
    end

    // Flag reads use the next transaction's column, pending reads the column after it.
    assign pend_raddr = column_next + AW'(1);
    assign flag_raddr = column_next;
    assign flag_we    = accept && have_pending_reg;

    assign pend_byp_valid_next = accept && (pend_raddr == column_reg);
    assign flag_byp_valid_next = flag_we && (flag_raddr == column_reg);

    ipr4_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_pending_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (column_reg),
        .wdata (raw),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    ipr4_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (column_reg),
        .wdata (res_full),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg         <= '0;
            have_pending_reg   <= 1'b0;
            have_above_reg     <= 1'b0;
            left_full_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            pend_byp_valid_reg <= 1'b0;
            flag_byp_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg         <= column_next;
            have_pending_reg   <= have_pending_next;
            have_above_reg     <= have_above_next;
            left_full_reg      <= left_full_next;
            out_valid_reg      <= out_valid_next;
            pend_byp_valid_reg <= pend_byp_valid_next;
            flag_byp_valid_reg <= flag_byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        col0_reg      <= col0_next;
        out_pixel_reg <= out_pixel_next;
        out_last_reg  <= out_last_next;
        pend_byp_reg  <= raw;
        flag_byp_reg  <= res_full;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### design/ipr4_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ipr4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/ipr4_cfg.sv
// Configuration register file behind the APB-style port.
module ipr4_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ipr4_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output ipr4_pkg::line_width_t            line_width
);
    import ipr4_pkg::*;

    line_width_t line_width_reg;
    line_width_t line_width_next;
    logic        wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready && (paddr == ADDR_LINE_WIDTH);

    always_comb
    begin
        line_width_next = line_width_reg;
        if (wr_hit)
        begin
            line_width_next = pwdata[LW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else
        begin
            line_width_reg <= line_width_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_LINE_WIDTH)
        begin
            prdata = {{(32 - LW_W){1'b0}}, line_width_reg};
        end
    end

    assign line_width = line_width_reg;

endmodule

### dv/tb_isolated_pixel_removal_4conn_unit.sv
// Self-checking testbench for the 4-connected isolated pixel removal unit.
`timescale 1ns / 1ps

module tb_isolated_pixel_removal_4conn_unit;
    import ipr4_pkg::*;

    localparam int MAX_W = 2048;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1500;

    typedef enum logic [1:0]
    {
        STEP_READ,
        STEP_WRITE,
        STEP_ITEM
    } step_op_t;

    // One row of the directed plan; chk marks a typed-in expected result.
    typedef struct packed
    {
        step_op_t    op;
        kind_t       kind;
        pixel_t      pix;
        line_width_t val;
        logic        chk;
        pixel_t      xpix;
        logic        xend;
    } plan_step_t;

    typedef struct packed
    {
        pixel_t pix;
        logic   fend;
    } filtered_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // pixel_in[7:0]
    logic        s_axis_tuser;   // kind[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // pixel_out[7:0]
    logic        m_axis_tlast;   // frame_end
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Filter state mirrored from the block.
    line_width_t width_reg;
    pixel_t      row_store [MAX_W];
    logic        full_above [MAX_W];
    logic        left_full;
    int          col_pos;
    logic        row_waiting;
    logic        above_valid;

    filtered_t   expected_pixels [$];
    int          errors;
    int          items_sent;
    logic        no_gaps;

    plan_step_t directed_plan [$] = '{
        '{STEP_READ,  KIND_PIXEL, 8'd0,   LINE_WIDTH_RESET, 1'b0, 8'd0,   1'b0},
        // Width 3: a lone 255 in the first row is cleared.
        '{STEP_WRITE, KIND_PIXEL, 8'd0,   12'd3,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd0,   12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd7,   12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd1,   12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b1, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd3,   12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b0, 8'd0,   1'b0},
        // Width 0 behaves as a single column: only above and below count.
        '{STEP_WRITE, KIND_PIXEL, 8'd0,   12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b1, 8'd255, 1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b1, 8'd255, 1'b1},
        // Width 2: a flush with nothing pending, then mixed kinds in one row.
        '{STEP_WRITE, KIND_PIXEL, 8'd0,   12'd2,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b1, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd4,   12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b1, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b1, 8'd0,   1'b1},
        // Width shrinks from 5 to 2 in the middle of the first row.
        '{STEP_WRITE, KIND_PIXEL, 8'd0,   12'd5,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_WRITE, KIND_PIXEL, 8'd0,   12'd2,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b1, 8'd255, 1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd0,   12'd0,    1'b1, 8'd255, 1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b1, 8'd255, 1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b1, 8'd0,   1'b1},
        // A width above the maximum, cut short by a width of 2 in the first row.
        '{STEP_WRITE, KIND_PIXEL, 8'd0,   12'd4095, 1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_WRITE, KIND_PIXEL, 8'd0,   12'd2,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd255, 12'd0,    1'b0, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd0,   12'd0,    1'b1, 8'd255, 1'b0},
        '{STEP_ITEM,  KIND_PIXEL, 8'd0,   12'd0,    1'b1, 8'd255, 1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b1, 8'd0,   1'b0},
        '{STEP_ITEM,  KIND_FLUSH, 8'd0,   12'd0,    1'b1, 8'd0,   1'b1}
    };

    isolated_pixel_removal_4conn_unit #(
        .MAX_WIDTH(MAX_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int eff_width();
        if (width_reg == '0)
            return 1;
        if (int'(width_reg) > MAX_W)
            return MAX_W;
        return int'(width_reg);
    endfunction

    function automatic int gap_cycles();
        return no_gaps ? 0 : $urandom_range(0, 11);
    endfunction

    // Filters one transaction; the result belongs to the pixel one row above it.
    function automatic logic filter_pixel(input kind_t kind, input pixel_t pix,
                                          output pixel_t res, output logic fend);
        int     w;
        int     c;
        logic   flush;
        logic   last;
        logic   any;
        logic   produced;
        pixel_t raw;
        pixel_t cur;
        w = eff_width();
        c = col_pos;
        flush = (kind == KIND_FLUSH);
        raw = flush ? '0 : pix;
        if (c >= MAX_W)
            c = MAX_W - 1;
        last = (c + 1 >= w);
        produced = 1'b0;
        res = '0;
        fend = 1'b0;
        if (row_waiting)
        begin
            cur = row_store[c];
            res = cur;
            if (cur != '0)
            begin
                any = (above_valid && full_above[c]) || (c > 0 && left_full)
                      || (!flush && raw == FULL_VALUE)
                      || (!last && row_store[c + 1] == FULL_VALUE);
                if (!any)
                    res = '0;
            end
            left_full = (res == FULL_VALUE);
            full_above[c] = left_full;
            fend = flush && last;
            produced = 1'b1;
        end
        row_store[c] = raw;
        if (last)
        begin
            col_pos = 0;
            left_full = 1'b0;
            if (flush)
            begin
                row_waiting = 1'b0;
                above_valid = 1'b0;
            end
            else
            begin
                above_valid = row_waiting;
                row_waiting = 1'b1;
            end
        end
        else
        begin
            col_pos = c + 1;
        end
        return produced;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic push_item(input kind_t kind, input pixel_t pix, input logic typed,
                             input pixel_t xpix, input logic xend);
        int        n;
        filtered_t res;
        filtered_t entry;
        logic      got;
        n = gap_cycles();
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= pix;
        do
            @(posedge clk);
        while (!s_axis_tready);
        got = filter_pixel(kind, pix, res.pix, res.fend);
        if (got)
        begin
            entry = typed ? filtered_t'{xpix, xend} : res;
            expected_pixels = {expected_pixels, entry};
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic reg_read_check(input line_width_t expv);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= ADDR_LINE_WIDTH;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[LW_W-1:0] !== expv)
        begin
            $error("line_width readback mismatch: expected %0d, got %0d",
                   expv, prdata[LW_W-1:0]);
            errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until the block is idle, writes the width and reads it back.
    task automatic width_write(input line_width_t val);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_LINE_WIDTH;
        pwdata <= 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        width_reg = val;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        reg_read_check(val);
    endtask

    function automatic pixel_t mask_pixel(input int density);
        int v;
        v = $urandom_range(0, 9);
        if (v < density)
            return FULL_VALUE;
        if (v < 9)
            return '0;
        return pixel_t'($urandom_range(0, 255));
    endfunction

    // One frame of well-formed rows, or of random kinds when noisy; may shrink
    // the width in the middle of a row, and always drains to the frame's end.
    task automatic run_frame(input line_width_t wval, input int rows);
        int    shrink_row;
        int    density;
        int    r;
        logic  noisy;
        logic  shrunk;
        kind_t kind;
        noisy = ($urandom_range(0, 7) == 0);
        shrink_row = ($urandom_range(0, 5) == 0) ? $urandom_range(0, rows - 1) : -1;
        density = $urandom_range(1, 8);
        shrunk = 1'b0;
        no_gaps = ($urandom_range(0, 4) == 0);
        width_write(wval);
        for (r = 0; r < rows; r++)
        begin
            do
            begin
                if (r == shrink_row && !shrunk && $urandom_range(0, 2) == 0)
                begin
                    width_write(line_width_t'($urandom_range(0, eff_width())));
                    shrunk = 1'b1;
                end
                if (noisy)
                    kind = kind_t'($urandom_range(0, 1));
                else
                    kind = ($urandom_range(0, 39) == 0) ? KIND_FLUSH : KIND_PIXEL;
                push_item(kind, mask_pixel(density), 1'b0, '0, 1'b0);
            end
            while (col_pos != 0);
        end
        while (col_pos != 0 || row_waiting)
            push_item(KIND_FLUSH, pixel_t'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
    endtask

    always @(posedge clk)
    begin : out_check
        filtered_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected output transaction: pixel_out %0d, frame_end %0d",
                       m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata !== want.pix)
                begin
                    $error("pixel_out mismatch: expected %0d, got %0d",
                           want.pix, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.fend)
                begin
                    $error("frame_end mismatch: expected %0d, got %0d",
                           want.fend, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Output side may stall a random number of cycles before each transaction.
    initial
    begin : sink
        int n;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = gap_cycles();
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    initial
    begin
        #40_000_000;
        $display("tb_isolated_pixel_removal_4conn_unit failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        width_reg = LINE_WIDTH_RESET;
        left_full = 1'b0;
        col_pos = 0;
        row_waiting = 1'b0;
        above_valid = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_plan[i])
        begin
            case (directed_plan[i].op)
                STEP_READ:
                    reg_read_check(directed_plan[i].val);
                STEP_WRITE:
                    width_write(directed_plan[i].val);
                default:
                    push_item(directed_plan[i].kind, directed_plan[i].pix,
                              directed_plan[i].chk, directed_plan[i].xpix,
                              directed_plan[i].xend);
            endcase
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                run_frame(line_width_t'($urandom_range(16, 80)), $urandom_range(1, 6));
            else
                run_frame(line_width_t'($urandom_range(0, 15)), $urandom_range(1, 6));
        end

        // One wide row, drained by a full row of flush transactions.
        run_frame(12'd200, 1);

        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("tb_isolated_pixel_removal_4conn_unit passed");
        else
            $display("tb_isolated_pixel_removal_4conn_unit failed");
        $finish;
    end

endmodule

### sim.f
design/ipr4_pkg.sv
design/ipr4_ram.sv
design/ipr4_cfg.sv
design/isolated_pixel_removal_4conn_unit.sv
dv/tb_isolated_pixel_removal_4conn_unit.sv
